// ----- src/srx_pkg.sv -----
// Shared types and constants for the serial frame receiver.
// Used by srx_front, srx_back and serial_frame_receiver_xor_top.
`default_nettype none
package srx_pkg;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_ID,
        PH_LEN,
        PH_DATA,
        PH_CHECK
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_SHOW
    } back_state_t;

    typedef enum logic [2:0] {
        REG_START_BYTE = 3'd0,
        REG_ARM_ID     = 3'd1,
        REG_CODE_ID    = 3'd2,
        REG_ARM_LEN    = 3'd3,
        REG_CODE_LEN   = 3'd4,
        REG_MAX_LEN    = 3'd5
    } reg_index_t;

    localparam logic KIND_ARM  = 1'b0;
    localparam logic KIND_CODE = 1'b1;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] arm_command_id;
        logic [7:0] code_command_id;
        logic [4:0] arm_command_length;
        logic [4:0] code_command_length;
        logic [4:0] max_payload_length;
    } cfg_t;

    // payload byte written into the frame store
    typedef struct packed {
        logic       en;
        logic       slot;
        logic [4:0] idx;
        logic [7:0] data;
    } mem_wr_t;

    // descriptor of a checked frame handed to the back end
    typedef struct packed {
        logic       valid;
        logic       slot;
        logic       kind;
        logic [4:0] len;
    } push_t;

endpackage
`default_nettype wire

// ----- src/srx_front.sv -----
// Front end: byte parser with running XOR checksum and frame classification.
// Depends on srx_pkg; writes payload into the store held by srx_back.
`default_nettype none
module srx_front #(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  srx_pkg::cfg_t       cfg,
    input  wire                 byte_valid,
    input  wire  [7:0]          rx_byte,
    output logic                byte_stall,
    input  wire  [1:0]          slot_busy,
    output srx_pkg::mem_wr_t    wr,
    output srx_pkg::push_t      push
);
    import srx_pkg::*;

    localparam logic [7:0] DEPTH_LIMIT = 8'(BUFFER_DEPTH);

    phase_t     phase_reg, phase_next;
    logic [7:0] command_id_reg, command_id_next;
    logic [4:0] expected_length_reg, expected_length_next;
    logic [4:0] byte_count_reg, byte_count_next;
    logic [7:0] running_xor_reg, running_xor_next;
    logic       wr_slot_reg, wr_slot_next;
    logic       take;
    logic [4:0] count_inc;

    assign byte_stall = (phase_reg == PH_DATA) && slot_busy[wr_slot_reg];
    assign take       = byte_valid && !byte_stall;
    assign count_inc  = byte_count_reg + 5'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_WAIT;
            command_id_reg      <= 8'd0;
            expected_length_reg <= 5'd0;
            byte_count_reg      <= 5'd0;
            running_xor_reg     <= 8'd0;
            wr_slot_reg         <= 1'b0;
        end
        else
        begin
            phase_reg           <= phase_next;
            command_id_reg      <= command_id_next;
            expected_length_reg <= expected_length_next;
            byte_count_reg      <= byte_count_next;
            running_xor_reg     <= running_xor_next;
            wr_slot_reg         <= wr_slot_next;
        end
    end

    always_comb
    begin
        phase_next           = phase_reg;
        command_id_next      = command_id_reg;
        expected_length_next = expected_length_reg;
        byte_count_next      = byte_count_reg;
        running_xor_next     = running_xor_reg;
        wr_slot_next         = wr_slot_reg;
        wr.en                = 1'b0;
        wr.slot              = wr_slot_reg;
        wr.idx               = byte_count_reg;
        wr.data              = rx_byte;
        push.valid           = 1'b0;
        push.slot            = wr_slot_reg;
        push.kind            = KIND_ARM;
        push.len             = expected_length_reg;

        if (take)
        begin
            unique case (phase_reg)
                PH_WAIT:
                begin
                    if (rx_byte == cfg.start_byte)
                    begin
                        phase_next = PH_ID;
                    end
                end
                PH_ID:
                begin
                    command_id_next = rx_byte;
                    phase_next      = PH_LEN;
                end
                PH_LEN:
                begin
                    byte_count_next      = 5'd0;
                    running_xor_next     = 8'd0;
                    expected_length_next = rx_byte[4:0];
                    if (rx_byte != 8'd0 && rx_byte <= {3'b000, cfg.max_payload_length}
                        && rx_byte <= DEPTH_LIMIT)
                    begin
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        phase_next = PH_WAIT;
                    end
                end
                PH_DATA:
                begin
                    wr.en            = 1'b1;
                    running_xor_next = running_xor_reg ^ rx_byte;
                    byte_count_next  = count_inc;
                    if (count_inc >= expected_length_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    phase_next = PH_WAIT;
                    if (rx_byte == running_xor_reg)
                    begin
                        if (command_id_reg == cfg.arm_command_id
                            && expected_length_reg == cfg.arm_command_length)
                        begin
                            push.valid   = 1'b1;
                            push.kind    = KIND_ARM;
                            wr_slot_next = !wr_slot_reg;
                        end
                        else if (command_id_reg == cfg.code_command_id
                            && expected_length_reg == cfg.code_command_length)
                        begin
                            push.valid   = 1'b1;
                            push.kind    = KIND_CODE;
                            wr_slot_next = !wr_slot_reg;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_WAIT;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- src/srx_back.sv -----
// Back end: two-slot frame store, descriptor queue and result beat output.
// Depends on srx_pkg; fed by srx_front.
`default_nettype none
module srx_back #(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  srx_pkg::mem_wr_t    wr,
    input  srx_pkg::push_t      push,
    output logic [1:0]          slot_busy,
    output logic                result_valid,
    input  wire                 result_stall,
    output logic                frame_kind,
    output logic [3:0]          byte_index,
    output logic [7:0]          payload_byte,
    output logic                last
);
    import srx_pkg::*;

    localparam int IDX_W  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int ADDR_W = IDX_W + 1;

    logic [7:0]  mem [2**ADDR_W];
    logic [7:0]  rd_data_reg;
    logic        rd_en;
    logic [ADDR_W-1:0] rd_addr;

    back_state_t state_reg, state_next;
    logic [1:0]  busy_reg, busy_next;
    logic [1:0]  kind_reg;
    logic [4:0]  len_reg [2];
    logic        rd_slot_reg, rd_slot_next;
    logic [4:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic        kind_out_reg;
    logic [3:0]  idx_out_reg;
    logic [7:0]  byte_out_reg;
    logic        last_out_reg;
    logic        load_out;
    logic        beat_done;

    assign slot_busy    = busy_reg;
    assign result_valid = out_valid_reg;
    assign frame_kind   = kind_out_reg;
    assign byte_index   = idx_out_reg;
    assign payload_byte = byte_out_reg;
    assign last         = last_out_reg;
    assign beat_done    = out_valid_reg && !result_stall;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[{wr.slot, IDX_W'(wr.idx)}] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (push.valid)
        begin
            kind_reg[push.slot] <= push.kind;
            len_reg[push.slot]  <= push.len;
        end
        if (load_out)
        begin
            kind_out_reg <= kind_reg[rd_slot_reg];
            idx_out_reg  <= idx_reg[3:0];
            byte_out_reg <= rd_data_reg;
            last_out_reg <= (idx_reg + 5'd1) == len_reg[rd_slot_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            busy_reg      <= 2'b00;
            rd_slot_reg   <= 1'b0;
            idx_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            rd_slot_reg   <= rd_slot_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        rd_slot_next   = rd_slot_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        rd_en          = 1'b0;
        rd_addr        = {rd_slot_reg, IDX_W'(idx_reg)};
        load_out       = 1'b0;

        if (push.valid)
        begin
            busy_next[push.slot] = 1'b1;
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                if (busy_reg[rd_slot_reg])
                begin
                    idx_next   = 5'd0;
                    rd_addr    = {rd_slot_reg, {IDX_W{1'b0}}};
                    rd_en      = 1'b1;
                    state_next = BK_FETCH;
                end
            end
            BK_FETCH:
            begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
                state_next     = BK_SHOW;
            end
            BK_SHOW:
            begin
                if (beat_done)
                begin
                    out_valid_next = 1'b0;
                    if (last_out_reg)
                    begin
                        busy_next[rd_slot_reg] = 1'b0;
                        rd_slot_next           = !rd_slot_reg;
                        state_next             = BK_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 5'd1;
                        rd_addr    = {rd_slot_reg, IDX_W'(idx_reg + 5'd1)};
                        rd_en      = 1'b1;
                        state_next = BK_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- src/serial_frame_receiver_xor_top.sv -----
// Top level of the serial frame receiver: APB register bank, parser front end
// and result back end. Depends on srx_pkg, srx_front and srx_back.
//
// Usage:
//   Byte channel (byte_valid, byte_stall, rx_byte): one received byte per beat.
//   Frames are start byte, command id, length, payload, XOR checksum.
//   Result channel (result_valid, result_stall, frame_kind, byte_index,
//   payload_byte, last): one payload byte per beat for each frame that passes
//   the checksum and matches the arm or code kind; last marks the final byte.
//   The first result beat follows the checksum beat via the slot busy flag,
//   the registered store read and the output registers. Input: one byte per
//   cycle while not stalled; the next result beat is read after one is taken.
//   The store holds two frames; the parser stalls the byte channel only while
//   collecting payload into a slot whose previous frame is still draining.
//   A stall on the result channel holds the current beat and, once both slots
//   are full, backs up into the byte channel.
//   Reset: parser hunts for the start byte, the store is empty, registers
//   return to their defaults (start 0xAA, arm id 1, code id 2, arm length 4,
//   code length 1, maximum 16). Registers lie at 4*i on the APB port.
`default_nettype none
module serial_frame_receiver_xor_top #(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         byte_valid,
    output logic        byte_stall,
    input  wire  [7:0]  rx_byte,
    output logic        result_valid,
    input  wire         result_stall,
    output logic        frame_kind,
    output logic [3:0]  byte_index,
    output logic [7:0]  payload_byte,
    output logic        last
);
    import srx_pkg::*;

    cfg_t       cfg_reg;
    logic       cfg_write;
    reg_index_t reg_sel;
    mem_wr_t    wr;
    push_t      push;
    logic [1:0] slot_busy;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_sel   = reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte          <= 8'd170;
            cfg_reg.arm_command_id      <= 8'd1;
            cfg_reg.code_command_id     <= 8'd2;
            cfg_reg.arm_command_length  <= 5'd4;
            cfg_reg.code_command_length <= 5'd1;
            cfg_reg.max_payload_length  <= 5'd16;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_START_BYTE: cfg_reg.start_byte          <= pwdata[7:0];
                REG_ARM_ID:     cfg_reg.arm_command_id      <= pwdata[7:0];
                REG_CODE_ID:    cfg_reg.code_command_id     <= pwdata[7:0];
                REG_ARM_LEN:    cfg_reg.arm_command_length  <= pwdata[4:0];
                REG_CODE_LEN:   cfg_reg.code_command_length <= pwdata[4:0];
                REG_MAX_LEN:    cfg_reg.max_payload_length  <= pwdata[4:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_START_BYTE: prdata = {24'd0, cfg_reg.start_byte};
            REG_ARM_ID:     prdata = {24'd0, cfg_reg.arm_command_id};
            REG_CODE_ID:    prdata = {24'd0, cfg_reg.code_command_id};
            REG_ARM_LEN:    prdata = {27'd0, cfg_reg.arm_command_length};
            REG_CODE_LEN:   prdata = {27'd0, cfg_reg.code_command_length};
            REG_MAX_LEN:    prdata = {27'd0, cfg_reg.max_payload_length};
            default:        prdata = 32'd0;
        endcase
    end

    srx_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .byte_valid (byte_valid),
        .rx_byte    (rx_byte),
        .byte_stall (byte_stall),
        .slot_busy  (slot_busy),
        .wr         (wr),
        .push       (push)
    );

    srx_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (wr),
        .push         (push),
        .slot_busy    (slot_busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .frame_kind   (frame_kind),
        .byte_index   (byte_index),
        .payload_byte (payload_byte),
        .last         (last)
    );

endmodule
`default_nettype wire
